// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the hit test rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication to the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/msht_pkg.sv
// ----------------------------------------------------------------------------
// msht_pkg
// types, constants and the arctangent table of the melee sector hit test
// ----------------------------------------------------------------------------
package msht_pkg;

  localparam int XyW  = 28;
  localparam int ZW   = 26;
  localparam int AngW = 24;
  localparam int TableLen = 24;

  localparam logic signed [ZW-1:0] HalfTurn = ZW'(26'sd8388608);
  localparam logic [16:0] GainQ16 = 17'd39797;

  typedef enum logic [2:0] {
    REG_RECT_WIDTH  = 3'd0,
    REG_RECT_HEIGHT = 3'd1,
    REG_PIVOT_X     = 3'd2,
    REG_PIVOT_Y     = 3'd3,
    REG_LIGHT_ARC   = 3'd4,
    REG_MEDIUM_ARC  = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_LIGHT  = 2'd0,
    KIND_MEDIUM = 2'd1,
    KIND_HEAVY  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef struct packed {
    logic signed [XyW-1:0] rx;
    logic signed [XyW-1:0] ry;
    logic signed [ZW-1:0]  rz;
    logic signed [XyW-1:0] ax;
    logic signed [XyW-1:0] ay;
    logic signed [ZW-1:0]  az;
    logic signed [XyW-1:0] cx;
    logic signed [XyW-1:0] cy;
    logic signed [ZW-1:0]  cz;
    logic                  zero_a;
    logic                  zero_c;
    logic [14:0]           radius;
    kind_e                 kind;
  } cordic_t;

  function automatic logic signed [ZW-1:0] atan_turns(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = ZW'(26'sd2097152);
      1:  r = ZW'(26'sd1238021);
      2:  r = ZW'(26'sd654136);
      3:  r = ZW'(26'sd332050);
      4:  r = ZW'(26'sd166669);
      5:  r = ZW'(26'sd83416);
      6:  r = ZW'(26'sd41718);
      7:  r = ZW'(26'sd20860);
      8:  r = ZW'(26'sd10430);
      9:  r = ZW'(26'sd5215);
      10: r = ZW'(26'sd2608);
      11: r = ZW'(26'sd1304);
      12: r = ZW'(26'sd652);
      13: r = ZW'(26'sd326);
      14: r = ZW'(26'sd163);
      15: r = ZW'(26'sd81);
      16: r = ZW'(26'sd41);
      17: r = ZW'(26'sd20);
      18: r = ZW'(26'sd10);
      19: r = ZW'(26'sd5);
      20: r = ZW'(26'sd3);
      21: r = ZW'(26'sd1);
      22: r = ZW'(26'sd1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/msht_cordic.sv
// ----------------------------------------------------------------------------
// msht_cordic
// pipelined cordic: one rotation lane and two vectoring lanes, one step a stage
// ----------------------------------------------------------------------------
module msht_cordic import msht_pkg::*; #(
  parameter int Steps = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    vld_i,
  input  cordic_t lane_i,
  output logic    vld_o,
  output cordic_t lane_o
);

  cordic_t stg_q [Steps];
  logic    vld_q [Steps];

  for (genvar i = 0; i < Steps; i++) begin : g_step
    cordic_t cur;
    logic    cur_vld;
    cordic_t stg_d;

    if (i == 0) begin : g_first
      assign cur     = lane_i;
      assign cur_vld = vld_i;
    end else begin : g_next
      assign cur     = stg_q[i-1];
      assign cur_vld = vld_q[i-1];
    end

    always_comb begin
      stg_d = cur;
      if (cur.rz >= 0) begin
        stg_d.rx = cur.rx - (cur.ry >>> i);
        stg_d.ry = cur.ry + (cur.rx >>> i);
        stg_d.rz = cur.rz - atan_turns(i);
      end else begin
        stg_d.rx = cur.rx + (cur.ry >>> i);
        stg_d.ry = cur.ry - (cur.rx >>> i);
        stg_d.rz = cur.rz + atan_turns(i);
      end
      if (cur.ay > 0) begin
        stg_d.ax = cur.ax + (cur.ay >>> i);
        stg_d.ay = cur.ay - (cur.ax >>> i);
        stg_d.az = cur.az + atan_turns(i);
      end else begin
        stg_d.ax = cur.ax - (cur.ay >>> i);
        stg_d.ay = cur.ay + (cur.ax >>> i);
        stg_d.az = cur.az - atan_turns(i);
      end
      if (cur.cy > 0) begin
        stg_d.cx = cur.cx + (cur.cy >>> i);
        stg_d.cy = cur.cy - (cur.cx >>> i);
        stg_d.cz = cur.cz + atan_turns(i);
      end else begin
        stg_d.cx = cur.cx - (cur.cy >>> i);
        stg_d.cy = cur.cy + (cur.cx >>> i);
        stg_d.cz = cur.cz - atan_turns(i);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= cur_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[i] <= stg_d;
      end
    end
  end

  assign vld_o  = vld_q[Steps-1];
  assign lane_o = stg_q[Steps-1];

endmodule

// File: rtl/melee_sector_hit_test_unit.sv
// ----------------------------------------------------------------------------
// melee_sector_hit_test_unit
// oriented rectangle against circle test, then an aim arc check per attack
// ----------------------------------------------------------------------------
// channel  | dir | contents
// s_axis   | in  | tdata: rect_x, rect_y, rect_angle, circle_x, circle_y,
//          |     |   circle_radius, aim_x, aim_y; tuser: attack_kind
// m_axis   | out | tdata: hit, touching
// cfg      | in  | register write, index and data
//
// one word per cycle while the output is not stalled; the path runs through the input
// and setup stages, the cordic step pipeline, then gain, clamp, square and output stages
// reset clears the valid bits and loads the register reset values
// a stalled output word freezes every stage; nothing is dropped or repeated
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module melee_sector_hit_test_unit import msht_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // rect_x, rect_y, rect_angle, circle_x, circle_y, circle_radius, aim_x, aim_y
  input  logic [127:0] s_axis_tdata,
  // attack_kind
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit, touching
  output logic [7:0]   m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i
);

  logic [14:0] width_q, height_q, pivx_q, pivy_q;
  logic [15:0] larc_q, marc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
      pivx_q   <= '0;
      pivy_q   <= '0;
      larc_q   <= 16'd16384;
      marc_q   <= 16'd32768;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_RECT_WIDTH:  width_q  <= cfg_data_i[14:0];
        REG_RECT_HEIGHT: height_q <= cfg_data_i[14:0];
        REG_PIVOT_X:     pivx_q   <= cfg_data_i[14:0];
        REG_PIVOT_Y:     pivy_q   <= cfg_data_i[14:0];
        REG_LIGHT_ARC:   larc_q   <= cfg_data_i;
        REG_MEDIUM_ARC:  marc_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_vld_q;
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // input stage: circle and aim offsets from the rectangle position
  logic signed [15:0] in_rx, in_ry, in_cx, in_cy, in_ax, in_ay;
  assign in_rx = s_axis_tdata[15:0];
  assign in_ry = s_axis_tdata[31:16];
  assign in_cx = s_axis_tdata[63:48];
  assign in_cy = s_axis_tdata[79:64];
  assign in_ax = s_axis_tdata[110:95];
  assign in_ay = s_axis_tdata[126:111];

  logic               s0_vld_q;
  logic signed [16:0] dx_q, dy_q, vax_q, vay_q;
  logic [15:0]        ang_q;
  logic [14:0]        rad0_q;
  kind_e              kind0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q    <= 17'(in_cx) - 17'(in_rx);
      dy_q    <= 17'(in_cy) - 17'(in_ry);
      vax_q   <= 17'(in_ax) - 17'(in_rx);
      vay_q   <= 17'(in_ay) - 17'(in_ry);
      ang_q   <= s_axis_tdata[47:32];
      rad0_q  <= s_axis_tdata[94:80];
      kind0_q <= kind_e'(s_axis_tuser);
    end
  end

  // setup stage: quadrant fold for rotation, half plane fold for vectoring
  cordic_t            setup_d, setup_q;
  logic               s1_vld_q;
  logic signed [17:0] z16;
  logic signed [XyW-1:0] sdx, sdy, sax, say;

  always_comb begin
    z16 = 18'(signed'(16'(-ang_q)));
    sdx = XyW'(dx_q) <<< 8;
    sdy = XyW'(dy_q) <<< 8;
    sax = XyW'(vax_q) <<< 8;
    say = XyW'(vay_q) <<< 8;
    setup_d        = '0;
    setup_d.rx     = sdx;
    setup_d.ry     = sdy;
    if (z16 > 18'sd16384) begin
      setup_d.rx = -sdx;
      setup_d.ry = -sdy;
      z16        = z16 - 18'sd32768;
    end else if (z16 < -18'sd16384) begin
      setup_d.rx = -sdx;
      setup_d.ry = -sdy;
      z16        = z16 + 18'sd32768;
    end
    setup_d.rz = ZW'(z16) <<< 8;
    if (sax < 0) begin
      setup_d.ax = -sax;
      setup_d.ay = -say;
      setup_d.az = HalfTurn;
    end else begin
      setup_d.ax = sax;
      setup_d.ay = say;
    end
    if (sdx < 0) begin
      setup_d.cx = -sdx;
      setup_d.cy = -sdy;
      setup_d.cz = HalfTurn;
    end else begin
      setup_d.cx = sdx;
      setup_d.cy = sdy;
    end
    setup_d.zero_a = (vax_q == '0) && (vay_q == '0);
    setup_d.zero_c = (dx_q == '0) && (dy_q == '0);
    setup_d.radius = rad0_q;
    setup_d.kind   = kind0_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      setup_q <= setup_d;
    end
  end

  logic    cor_vld;
  cordic_t cor;

  msht_cordic #(.Steps(CORDIC_STEPS)) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s1_vld_q),
    .lane_i (setup_q),
    .vld_o  (cor_vld),
    .lane_o (cor)
  );

  // gain stage: scale back to q22.0 and form the angle gap
  logic signed [45:0] gx, gy;
  logic [AngW-1:0]    dir_a, dir_c, gap;
  logic [AngW:0]      mag_d;
  logic               p1_vld_q;
  logic signed [21:0] lx_q, ly_q;
  logic [AngW:0]      mag_q;
  logic [14:0]        rad1_q;
  kind_e              kind1_q;

  always_comb begin
    gx    = 46'(cor.rx) * signed'({1'b0, GainQ16}) + 46'sd8388608;
    gy    = 46'(cor.ry) * signed'({1'b0, GainQ16}) + 46'sd8388608;
    dir_a = cor.zero_a ? '0 : cor.az[AngW-1:0];
    dir_c = cor.zero_c ? '0 : cor.cz[AngW-1:0];
    gap   = dir_c - dir_a;
    mag_d = gap[AngW-1] ? ((AngW+1)'(1) << AngW) - (AngW+1)'(gap) : (AngW+1)'(gap);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else if (en) begin
      p1_vld_q <= cor_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lx_q    <= gx[45:24];
      ly_q    <= gy[45:24];
      mag_q   <= mag_d;
      rad1_q  <= cor.radius;
      kind1_q <= cor.kind;
    end
  end

  // clamp stage
  logic signed [22:0] lox, hix, loy, hiy, wx, wy, clx, cly;
  logic               p2_vld_q;
  logic signed [22:0] ex_q, ey_q;
  logic               arc_d, arc_q;
  logic [14:0]        rad2_q;

  always_comb begin
    lox = -23'(pivx_q);
    hix = 23'(width_q) - 23'(pivx_q);
    loy = -23'(pivy_q);
    hiy = 23'(height_q) - 23'(pivy_q);
    wx  = 23'(lx_q);
    wy  = 23'(ly_q);
    if (wx < lox)      clx = lox;
    else if (wx > hix) clx = hix;
    else               clx = wx;
    if (wy < loy)      cly = loy;
    else if (wy > hiy) cly = hiy;
    else               cly = wy;
    case (kind1_q)
      KIND_LIGHT:  arc_d = mag_q <= (AngW+1)'({larc_q, 7'd0});
      KIND_MEDIUM: arc_d = mag_q <= (AngW+1)'({marc_q, 7'd0});
      KIND_HEAVY:  arc_d = 1'b1;
      default:     arc_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_vld_q <= 1'b0;
    end else if (en) begin
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ex_q   <= wx - clx;
      ey_q   <= wy - cly;
      arc_q  <= arc_d;
      rad2_q <= rad1_q;
    end
  end

  // square stage
  logic         p3_vld_q;
  logic [44:0]  sqx_q, sqy_q;
  logic [29:0]  sqr_q;
  logic         arc3_q;
  logic signed [45:0] px, py;

  assign px = 46'(ex_q) * 46'(ex_q);
  assign py = 46'(ey_q) * 46'(ey_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_vld_q <= 1'b0;
    end else if (en) begin
      p3_vld_q <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q  <= px[44:0];
      sqy_q  <= py[44:0];
      sqr_q  <= rad2_q * rad2_q;
      arc3_q <= arc_q;
    end
  end

  // output stage
  logic [45:0] dsq;
  logic        touch_d;
  logic        hit_q, touch_q;

  assign dsq     = 46'(sqx_q) + 46'(sqy_q);
  assign touch_d = dsq < 46'(sqr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= p3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q   <= touch_d && arc3_q;
      touch_q <= touch_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, touch_q, hit_q};

  `ASSERT_ALWAYS(a_hit_needs_touch, !(out_vld_q && hit_q && !touch_q),
    "hit without touching")
  `ASSERT_NEXT(a_last_stage_lands, p3_vld_q && en, out_vld_q,
    "square stage word did not reach the output")
  `ASSERT_NEXT(a_stall_freezes, out_vld_q && !m_axis_tready,
    out_vld_q && $stable(p3_vld_q) && $stable(cor_vld), "pipeline moved under stall")

endmodule

// File: tb/melee_sector_hit_test_unit_tb.sv
// ----------------------------------------------------------------------------
// melee_sector_hit_test_unit_tb
// self-checking bench for the rectangle against circle hit test: a directed
// table, then random words over several register settings, with random idle
// on both sides, a long output stall and a drain pause; each result word is held
// to its typed entry or an in-bench fixed-point model of the cordic datapath
// ----------------------------------------------------------------------------
module melee_sector_hit_test_unit_tb;
  import msht_pkg::*;

  localparam int Steps = 16;
  localparam int DrainCycles = Steps + 12;
  localparam int WatchLimit = 4000;
  localparam logic [2:0] RegBeyondLo = 3'd6;
  localparam logic [2:0] RegBeyondHi = 3'd7;
  localparam longint AtanTab [24] = '{
    2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
    10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};

  typedef struct packed {
    logic signed [15:0] rx, ry;
    logic [15:0]        ang;
    logic signed [15:0] cx, cy;
    logic [14:0]        rad;
    logic signed [15:0] ax, ay;
    kind_e              kind;
    logic               typed, hit, touching;
  } hit_case_t;

  typedef struct packed {
    logic hit, touching;
  } hit_res_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [7:0]   m_axis_tdata;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [15:0]  cfg_data_i = '0;

  longint   rect_w, rect_h, piv_x, piv_y, arc_light, arc_medium;
  hit_res_t hit_q[$];
  hit_case_t cur_case;
  int       err_cnt = 0;
  int       idle_cnt = 0;
  bit       calm = 1'b0;
  bit       hold_req = 1'b0;
  int       hold_cnt = 0;
  hit_case_t dir_tab[12];

  always #4 clk_i = ~clk_i;

  melee_sector_hit_test_unit #(.CORDIC_STEPS(Steps)) u_top (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  function automatic void rotate_local(input longint dx, input longint dy,
                                       input logic [15:0] ang,
                                       output longint lx, output longint ly);
    longint x, y, z, nx, ny;
    int     z16;
    x = dx * 256;
    y = dy * 256;
    z16 = (65536 - int'(ang)) & 16'hFFFF;
    if (z16 >= 32768) z16 -= 65536;
    if (z16 > 16384) begin
      x = -x; y = -y; z16 -= 32768;
    end else if (z16 < -16384) begin
      x = -x; y = -y; z16 += 32768;
    end
    z = longint'(z16) * 256;
    for (int i = 0; i < Steps && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= AtanTab[i];
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += AtanTab[i];
      end
      x = nx; y = ny;
    end
    lx = (x * 39797 + 8388608) >>> 24;
    ly = (y * 39797 + 8388608) >>> 24;
  endfunction

  function automatic longint heading(input longint vx, input longint vy);
    longint x, y, z, nx, ny, base;
    if (vx == 0 && vy == 0) return 0;
    x = vx * 256;
    y = vy * 256;
    z = 0;
    base = 0;
    if (x < 0) begin
      x = -x; y = -y; base = 8388608;
    end
    for (int i = 0; i < Steps && i < 24; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += AtanTab[i];
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= AtanTab[i];
      end
      x = nx; y = ny;
    end
    return (base + z) & 24'hFFFFFF;
  endfunction

  function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic hit_res_t predict_hit(input logic [127:0] d, input logic [1:0] k);
    longint   rx, ry, cx, cy, rad, ax, ay, dx, dy, lx, ly, ex, ey, diff, mag;
    hit_res_t r;
    rx = longint'($signed(d[15:0]));
    ry = longint'($signed(d[31:16]));
    cx = longint'($signed(d[63:48]));
    cy = longint'($signed(d[79:64]));
    rad = longint'(d[94:80]);
    ax = longint'($signed(d[110:95]));
    ay = longint'($signed(d[126:111]));
    dx = cx - rx;
    dy = cy - ry;
    rotate_local(dx, dy, d[47:32], lx, ly);
    ex = lx - clamp_to(lx, -piv_x, rect_w - piv_x);
    ey = ly - clamp_to(ly, -piv_y, rect_h - piv_y);
    r.touching = (ex * ex + ey * ey) < rad * rad;
    r.hit = 1'b0;
    if (r.touching) begin
      diff = (heading(dx, dy) - heading(ax - rx, ay - ry)) & 24'hFFFFFF;
      mag = (diff >= 8388608) ? 16777216 - diff : diff;
      case (kind_e'(k))
        KIND_LIGHT:  r.hit = mag <= arc_light * 128;
        KIND_MEDIUM: r.hit = mag <= arc_medium * 128;
        KIND_HEAVY:  r.hit = 1'b1;
        default:     r.hit = 1'b0;
      endcase
    end
    return r;
  endfunction

  // scoreboard
  always @(posedge clk_i) begin
    hit_res_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (hit_q.size() == 0) begin
        $error("result word with no expectation: %h", m_axis_tdata);
        err_cnt++;
      end else begin
        want = hit_q.pop_front();
        if (m_axis_tdata[0] !== want.hit) begin
          $error("hit: expected %0b actual %0b", want.hit, m_axis_tdata[0]);
          err_cnt++;
        end
        if (m_axis_tdata[1] !== want.touching) begin
          $error("touching: expected %0b actual %0b", want.touching, m_axis_tdata[1]);
          err_cnt++;
        end
      end
    end
    if (s_axis_tvalid && s_axis_tready) begin
      if (cur_case.typed) hit_q.push_back('{hit: cur_case.hit, touching: cur_case.touching});
      else hit_q.push_back(predict_hit(s_axis_tdata, s_axis_tuser));
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req <= 1'b0;
      hold_cnt <= 300;
      m_axis_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 25);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WatchLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_word(input hit_case_t c);
    while (!calm && $urandom_range(99) < 25) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, c.ay, c.ax, c.rad, c.cy, c.cx, c.ang, c.ry, c.rx};
    s_axis_tuser <= c.kind;
    cur_case <= c;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (hit_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_RECT_WIDTH:  rect_w = val[14:0];
      REG_RECT_HEIGHT: rect_h = val[14:0];
      REG_PIVOT_X:     piv_x = val[14:0];
      REG_PIVOT_Y:     piv_y = val[14:0];
      REG_LIGHT_ARC:   arc_light = val;
      REG_MEDIUM_ARC:  arc_medium = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic load_regs(input int w, input int h, input int px, input int py,
                           input int la, input int ma);
    write_reg(REG_RECT_WIDTH, 16'(w));
    write_reg(REG_RECT_HEIGHT, 16'(h));
    write_reg(REG_PIVOT_X, 16'(px));
    write_reg(REG_PIVOT_Y, 16'(py));
    write_reg(REG_LIGHT_ARC, 16'(la));
    write_reg(REG_MEDIUM_ARC, 16'(ma));
    write_reg(RegBeyondLo, 16'($urandom));
    write_reg(RegBeyondHi, 16'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  function automatic hit_case_t rand_case();
    hit_case_t c;
    c = '0;
    c.ang = 16'($urandom);
    c.kind = kind_e'($urandom_range(3));
    c.ax = 16'($urandom);
    c.ay = 16'($urandom);
    if ($urandom_range(99) < 80) begin
      c.rx = 16'($urandom_range(8000) - 4000);
      c.ry = 16'($urandom_range(8000) - 4000);
      c.cx = c.rx + 16'($urandom_range(3000) - 1500);
      c.cy = c.ry + 16'($urandom_range(3000) - 1500);
      c.rad = 15'($urandom_range(1200));
      if ($urandom_range(3) == 0) begin
        c.ax = c.rx + 16'($urandom_range(2000) - 1000);
        c.ay = c.ry + 16'($urandom_range(2000) - 1000);
      end
    end else begin
      c.rx = 16'($urandom);
      c.ry = 16'($urandom);
      c.cx = 16'($urandom);
      c.cy = 16'($urandom);
      c.rad = 15'($urandom);
    end
    return c;
  endfunction

  task automatic random_run(input int n, input int hold_at, input int pause_at);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      if (i == pause_at) wait_drained();
      send_word(rand_case());
    end
    wait_drained();
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    rect_w = 0; rect_h = 0; piv_x = 0; piv_y = 0;
    arc_light = 16384; arc_medium = 32768;
    cur_case = '0;
    dir_tab[0]  = '{0, 0, 0, 0, 0, 0, 0, 0, KIND_LIGHT, 1, 0, 0};
    dir_tab[1]  = '{0, 0, 0, 0, 0, 1, 0, 0, KIND_HEAVY, 1, 1, 1};
    dir_tab[2]  = '{0, 0, 0, 0, 0, 1, 0, 0, KIND_NONE, 1, 0, 1};
    dir_tab[3]  = '{0, 0, 0, 0, 0, 1, 0, 0, KIND_LIGHT, 1, 1, 1};
    dir_tab[4]  = '{-32768, -32768, 0, 32767, 32767, 32767, 0, 0, KIND_HEAVY, 0, 0, 0};
    dir_tab[5]  = '{32767, 32767, 65535, -32768, -32768, 32767, -32768, 32767,
                    KIND_LIGHT, 0, 0, 0};
    dir_tab[6]  = '{100, 100, 16384, 150, 120, 200, 400, 100, KIND_MEDIUM, 0, 0, 0};
    dir_tab[7]  = '{100, 100, 32768, 50, 80, 200, -400, 100, KIND_MEDIUM, 0, 0, 0};
    dir_tab[8]  = '{-200, 300, 49152, -180, 330, 100, -200, 900, KIND_LIGHT, 0, 0, 0};
    dir_tab[9]  = '{0, 0, 8192, 400, 400, 32767, 400, -400, KIND_LIGHT, 0, 0, 0};
    dir_tab[10] = '{0, 0, 40000, -300, 0, 500, -1, 0, KIND_NONE, 0, 0, 0};
    dir_tab[11] = '{-5, -5, 24576, 0, 0, 8, 32767, -32768, KIND_MEDIUM, 0, 0, 0};
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (dir_tab[i]) send_word(dir_tab[i]);
    random_run(100, -1, -1);
    load_regs(32767, 32767, 0, 0, 0, 65535);
    calm = 1'b1;
    random_run(120, -1, -1);
    calm = 1'b0;
    load_regs(0, 0, 32767, 32767, 65535, 0);
    random_run(120, 40, -1);
    load_regs($urandom_range(4000), $urandom_range(4000), $urandom_range(2000),
              $urandom_range(2000), $urandom_range(65535), $urandom_range(65535));
    random_run(130, -1, 60);
    load_regs($urandom_range(32767), $urandom_range(1500), $urandom_range(32767),
              $urandom_range(800), $urandom_range(65535), $urandom_range(65535));
    random_run(130, -1, -1);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0 && hit_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
